@@ rtl/mcw_pkg.sv @@
`default_nettype none
package mcw_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT  = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_KERNEL_HEIGHT = 3'd3,
        REG_KERNEL_WIDTH  = 3'd4
    } t_reg_index;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    typedef struct packed {
        logic store_weight;
        logic store_pixel;
        logic clear_acc;
        logic issue_read;
        logic do_mul;
        logic do_acc;
        logic step_tap;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic tap_last;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/multichannel_conv_window_mac.sv @@
// Channel   Handshake               Payload
// input     i_valid / o_stall       i_op, i_tap_channel, i_tap_row, i_tap_col, i_sample
// output    o_valid / i_stall       o_result, o_out_row, o_out_col, o_last_of_image
// config    i_cfg_we                i_cfg_index, i_cfg_data
// A weight word is stored and leaves the input free. A pixel word is stored and stalls
// the input for the window check and, if it completes one, while each tap is read,
// multiplied and added by the single shared multiply-accumulate unit from line memory.
// Reset is synchronous and active low; memories are not cleared.
// The output register holds a stalled word while further input is taken; a second
// result then waits in the accumulator and the input stalls until the word leaves.
`default_nettype none
module multichannel_conv_window_mac
    import mcw_pkg::*;
#(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_KERNEL   = 5
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [2:0]         i_cfg_index,
    input  wire [6:0]         i_cfg_data,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_op,
    input  wire [3:0]         i_tap_channel,
    input  wire [2:0]         i_tap_row,
    input  wire [2:0]         i_tap_col,
    input  wire signed [15:0] i_sample,
    output logic              o_valid,
    input  wire               i_stall,
    output logic signed [15:0] o_result,
    output logic [5:0]        o_out_row,
    output logic [5:0]        o_out_col,
    output logic              o_last_of_image
);

    t_cmd    w_cmd;
    t_status w_status;

    mcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mcw_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_tap_channel   (i_tap_channel),
        .i_tap_row       (i_tap_row),
        .i_tap_col       (i_tap_col),
        .i_sample        (i_sample),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_result        (o_result),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_image (o_last_of_image)
    );

endmodule
`default_nettype wire

@@ rtl/mcw_ctrl.sv @@
`default_nettype none
module mcw_ctrl
    import mcw_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_valid,
    input  wire     i_op,
    output logic    o_stall,
    output logic    o_valid,
    input  wire     i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    logic   w_take;

    assign w_take  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = (i_op == OP_PIXEL) ? ST_WRITE : ST_IDLE;
                end
            end
            ST_WRITE: begin
                n_state = i_status.emit ? ST_READ : ST_IDLE;
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                n_state = i_status.tap_last ? ST_OUT : ST_READ;
            end
            ST_OUT: begin
                if (!r_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_valid = r_valid && i_stall;
        case (r_state)
            ST_IDLE: begin
                o_cmd.store_weight = w_take && (i_op == OP_WEIGHT);
                o_cmd.store_pixel  = w_take && (i_op == OP_PIXEL);
            end
            ST_WRITE: o_cmd.clear_acc = 1'b1;
            ST_READ:  o_cmd.issue_read = 1'b1;
            ST_MUL:   o_cmd.do_mul = 1'b1;
            ST_ACC: begin
                o_cmd.do_acc   = 1'b1;
                o_cmd.step_tap = 1'b1;
            end
            ST_OUT: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_valid = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid)
        else $error("stalled word dropped");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_valid || !i_stall))
        else $error("output overwritten");

endmodule
`default_nettype wire

@@ rtl/mcw_datapath.sv @@
`default_nettype none
module mcw_datapath
    import mcw_pkg::*;
#(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_KERNEL   = 5
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [2:0]         i_cfg_index,
    input  wire [6:0]         i_cfg_data,
    input  wire [3:0]         i_tap_channel,
    input  wire [2:0]         i_tap_row,
    input  wire [2:0]         i_tap_col,
    input  wire signed [15:0] i_sample,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic signed [15:0] o_result,
    output logic [5:0]        o_out_row,
    output logic [5:0]        o_out_col,
    output logic              o_last_of_image
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int LD = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
    localparam int WD = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int LAW = $clog2(LD);
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

    logic [6:0] r_height;
    logic [6:0] r_width;
    logic [4:0] r_chans;
    logic [2:0] r_kh;
    logic [2:0] r_kw;

    logic [15:0] r_line [LD];
    logic [15:0] r_weight [WD];

    logic [YW-1:0] r_row;
    logic [XW-1:0] r_col;
    logic [CW-1:0] r_ch;
    logic [KW-1:0] r_ring_mod;
    logic [KW-1:0] r_base_mod;
    logic [YW-1:0] r_r0;
    logic [XW-1:0] r_c0;
    logic          r_last;
    logic          r_last_img;

    logic [CW-1:0] r_tz;
    logic [KW-1:0] r_ty;
    logic [KW-1:0] r_tx;
    logic [15:0]   r_pix;
    logic [15:0]   r_wgt;
    logic signed [31:0] r_prod;
    logic [15:0]   r_acc;

    logic [10:0] w_h;
    logic [10:0] w_w;
    logic [6:0]  w_nc;
    logic [3:0]  w_kh;
    logic [3:0]  w_kw;
    logic [10:0] w_row;
    logic [10:0] w_col;
    logic [6:0]  w_ch;
    logic        w_wrap;
    logic [YW-1:0] w_row_e;
    logic [XW-1:0] w_col_e;
    logic [CW-1:0] w_ch_e;
    logic [KW-1:0] w_mod_e;
    logic        w_emit;
    logic [KW:0] w_ysum;
    logic [KW-1:0] w_yrow;
    logic [XW:0] w_xsum;
    logic [LAW-1:0] w_laddr;
    logic [WAW-1:0] w_waddr_rd;
    logic [WAW-1:0] w_waddr_wr;
    logic        w_wr_ok;

    function automatic logic [10:0] clamp11(input logic [6:0] v, input int hi);
        logic [10:0] r;
        r = {4'd0, v};
        if (v == 7'd0) r = 11'd1;
        else if (int'(v) > hi) r = 11'(hi);
        return r;
    endfunction

    assign w_h  = clamp11(r_height, MAX_HEIGHT);
    assign w_w  = clamp11(r_width, MAX_WIDTH);
    assign w_nc = 7'(clamp11({2'd0, r_chans}, MAX_CHANNELS));
    assign w_kh = 4'(clamp11({4'd0, r_kh}, MAX_KERNEL));
    assign w_kw = 4'(clamp11({4'd0, r_kw}, MAX_KERNEL));

    assign w_row = 11'(r_row);
    assign w_col = 11'(r_col);
    assign w_ch  = 7'(r_ch);
    assign w_wrap = (w_row >= w_h) || (w_col >= w_w) || (w_ch >= w_nc);
    assign w_row_e = w_wrap ? '0 : r_row;
    assign w_col_e = w_wrap ? '0 : r_col;
    assign w_ch_e  = w_wrap ? '0 : r_ch;
    assign w_mod_e = w_wrap ? '0 : r_ring_mod;
    assign w_emit = (7'(w_ch_e) + 7'd1 == w_nc)
                 && (11'(w_row_e) + 11'd1 >= 11'(w_kh))
                 && (11'(w_col_e) + 11'd1 >= 11'(w_kw));

    assign w_ysum = (KW+1)'(r_base_mod) + (KW+1)'(r_ty);
    assign w_yrow = (w_ysum >= (KW+1)'(MAX_KERNEL))
                  ? KW'(w_ysum - (KW+1)'(MAX_KERNEL)) : KW'(w_ysum);
    assign w_xsum = (XW+1)'(r_c0) + (XW+1)'(r_tx);
    assign w_laddr = LAW'(((int'(w_yrow) * MAX_WIDTH + int'(w_xsum[XW-1:0]))
                     * MAX_CHANNELS) + int'(r_tz));
    assign w_waddr_rd = WAW'((int'(r_tz) * MAX_KERNEL + int'(r_ty)) * MAX_KERNEL
                        + int'(r_tx));
    assign w_waddr_wr = WAW'((int'(i_tap_channel) * MAX_KERNEL + int'(i_tap_row))
                        * MAX_KERNEL + int'(i_tap_col));
    assign w_wr_ok = (int'(i_tap_channel) < MAX_CHANNELS)
                  && (int'(i_tap_row) < MAX_KERNEL) && (int'(i_tap_col) < MAX_KERNEL);

    assign o_status.emit = r_last;
    assign o_status.tap_last = (7'(r_tz) + 7'd1 == w_nc)
                            && (4'(r_ty) + 4'd1 == w_kh)
                            && (4'(r_tx) + 4'd1 == w_kw);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pixel) begin
            r_line[LAW'((int'(w_mod_e) * MAX_WIDTH + int'(w_col_e)) * MAX_CHANNELS
                   + int'(w_ch_e))] <= i_sample;
        end
        if (i_cmd.store_weight && w_wr_ok) begin
            r_weight[w_waddr_wr] <= i_sample;
        end
        if (i_cmd.issue_read) begin
            r_pix <= r_line[w_laddr];
            r_wgt <= r_weight[w_waddr_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 7'd12;
            r_width  <= 7'd12;
            r_chans  <= 5'd10;
            r_kh     <= 3'd3;
            r_kw     <= 3'd3;
            r_row <= '0;
            r_col <= '0;
            r_ch  <= '0;
            r_ring_mod <= '0;
            r_last <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index <= REG_KERNEL_WIDTH)) begin
            case (t_reg_index'(i_cfg_index))
                REG_IMAGE_HEIGHT:  r_height <= i_cfg_data;
                REG_IMAGE_WIDTH:   r_width  <= i_cfg_data;
                REG_CHANNEL_COUNT: r_chans  <= i_cfg_data[4:0];
                REG_KERNEL_HEIGHT: r_kh     <= i_cfg_data[2:0];
                REG_KERNEL_WIDTH:  r_kw     <= i_cfg_data[2:0];
                default: r_kw <= r_kw;
            endcase
            r_row <= '0;
            r_col <= '0;
            r_ch  <= '0;
            r_ring_mod <= '0;
        end else if (i_cmd.store_pixel) begin
            r_last <= w_emit;
            r_ch <= w_ch_e + 1'b1;
            r_row <= w_row_e;
            r_col <= w_col_e;
            r_ring_mod <= w_mod_e;
            if (7'(w_ch_e) + 7'd1 >= w_nc) begin
                r_ch <= '0;
                r_col <= w_col_e + 1'b1;
                if (11'(w_col_e) + 11'd1 >= w_w) begin
                    r_col <= '0;
                    r_row <= w_row_e + 1'b1;
                    r_ring_mod <= (int'(w_mod_e) == MAX_KERNEL - 1) ? '0 : w_mod_e + 1'b1;
                    if (11'(w_row_e) + 11'd1 >= w_h) begin
                        r_row <= '0;
                        r_ring_mod <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pixel) begin
            r_r0 <= YW'(11'(w_row_e) + 11'd1 - 11'(w_kh));
            r_c0 <= XW'(11'(w_col_e) + 11'd1 - 11'(w_kw));
            r_base_mod <= (4'(w_mod_e) + 4'd1 >= w_kh)
                        ? KW'(4'(w_mod_e) + 4'd1 - w_kh)
                        : KW'(4'(w_mod_e) + 4'd1 + 4'(MAX_KERNEL) - w_kh);
            r_last_img <= (11'(w_row_e) + 11'd1 == w_h)
                       && (11'(w_col_e) + 11'd1 == w_w);
        end
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
            r_tz <= '0;
            r_ty <= '0;
            r_tx <= '0;
        end
        if (i_cmd.do_mul) begin
            r_prod <= $signed(r_pix) * $signed(r_wgt);
        end
        if (i_cmd.do_acc) begin
            r_acc <= r_acc + r_prod[15:0];
        end
        if (i_cmd.step_tap) begin
            r_tx <= r_tx + 1'b1;
            if (4'(r_tx) + 4'd1 >= w_kw) begin
                r_tx <= '0;
                r_ty <= r_ty + 1'b1;
                if (4'(r_ty) + 4'd1 >= w_kh) begin
                    r_ty <= '0;
                    r_tz <= r_tz + 1'b1;
                end
            end
        end
        if (i_cmd.load_out) begin
            o_result        <= r_acc;
            o_out_row       <= 6'(r_r0);
            o_out_col       <= 6'(r_c0);
            o_last_of_image <= r_last_img;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_pixel |=> (int'(r_ring_mod) < MAX_KERNEL))
        else $error("line ring index out of range");

endmodule
`default_nettype wire
